>>> design/multilink_fragment_scheduler_core_assert.svh
// Assertion macros shared by the checker.
// Both macros sample on clk and are switched off while rst is high.
`ifndef MULTILINK_FRAGMENT_SCHEDULER_CORE_ASSERT_SVH
`define MULTILINK_FRAGMENT_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication.
`define MLFS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MLFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mlfs_pkg.sv
package mlfs_pkg;

  // Field widths
  localparam int LEN_W     = 12;
  localparam int CNT_W     = 4;
  localparam int MASK_W    = 8;
  localparam int LINK_W    = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = 4;

  // Bundle and frame limits
  localparam int MAX_LINKS = 8;
  localparam int LINK_LIM  = (MAX_LINKS < MASK_W) ? MAX_LINKS : MASK_W;
  localparam logic [LEN_W-1:0] MAX_FRAME   = 12'd2048;
  localparam logic [LEN_W-1:0] MIN_PKT_LEN = 12'h019;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MRU      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MRRU     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAG = 2'd2;
  localparam logic [CFG_W-1:0]     MRU_RESET      = 16'd1500;
  localparam logic [CFG_W-1:0]     MRRU_RESET     = 16'd0;
  localparam logic [LEN_W-1:0]     MIN_FRAG_RESET = 12'd64;

  // Divider: two quotient bits per cycle
  localparam int DIV_STEPS = LEN_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_SENT     = 3'd0,
    ST_SHORT    = 3'd1,
    ST_OVERSIZE = 3'd2,
    ST_OVER_MRU = 3'd3,
    ST_NO_LINK  = 3'd4
  } status_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> design/multilink_fragment_scheduler_core.sv
// A dropped or plain packet passes S_CHECK and S_ONE and gives its one result once the
// result slot is free. A bundle packet first takes one remainder pass of the shared
// two-bit-per-cycle divider; a fragmented one takes a second pass, quotient, and fragments
// follow one per cycle while the result is not stalled. No new packet is taken until the
// last result is registered, as item_stall is high outside S_IDLE. Synchronous rst sets
// mru 1500, mrru 0, min_frag_len 64 and clears the rotation index and all valid flags.
module multilink_fragment_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [11:0] packet_length,
  input  logic [3:0]  member_count,
  input  logic [7:0]  opened_mask,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [2:0]  link_index,
  output logic [11:0] frag_offset,
  output logic [11:0] frag_length,
  output logic        mp_header,
  output logic        mp_start,
  output logic        mp_end,
  output logic        last
);

  localparam int LW = mlfs_pkg::LEN_W;
  localparam int MW = mlfs_pkg::MASK_W;
  localparam int KW = mlfs_pkg::LINK_W;
  localparam int DW = mlfs_pkg::DIV_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MOD, S_DIV, S_ONE, S_FRAG
  } state_t;

  state_t state;

  logic [15:0]   mru;
  logic [15:0]   mrru;
  logic [LW-1:0] min_frag_len;
  logic [KW-1:0] rot;

  logic [LW-1:0] len_q;
  logic [3:0]    count_q;
  logic [MW-1:0] mask_q;
  logic [MW-1:0] emask_q;
  logic [DW-1:0] nb_q;
  mlfs_pkg::status_t pend_status;
  logic          bundle;
  logic [LW-1:0] flen;
  logic [LW-1:0] off_q;
  logic [1:0]    frag_idx;
  logic [1:0]    frag_last_idx;

  mlfs_pkg::div_req_t div_req;
  mlfs_pkg::div_rsp_t div_rsp;

  logic [MW-1:0] eff_mask;
  logic [DW-1:0] nb_c;
  logic [DW-1:0] prefix;
  logic [KW-1:0] sel_link;
  logic [DW-1:0] div_sel;
  logic [KW-1:0] rot_inc;
  logic [DW-1:0] rot_plus;
  logic          over_mru;
  logic          slot_free;
  logic          is_last;

  mlfs_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mru          <= mlfs_pkg::MRU_RESET;
      mrru         <= mlfs_pkg::MRRU_RESET;
      min_frag_len <= mlfs_pkg::MIN_FRAG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlfs_pkg::REG_MRU:      mru          <= cfg_data;
        mlfs_pkg::REG_MRRU:     mrru         <= cfg_data;
        mlfs_pkg::REG_MIN_FRAG: min_frag_len <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // Opened members within the bundle and their count
  always_comb begin
    nb_c = '0;
    for (int i = 0; i < MW; i++) begin
      eff_mask[i] = mask_q[i] && (i < mlfs_pkg::LINK_LIM) && (i < int'(count_q));
      nb_c        = nb_c + {{(DW-1){1'b0}}, eff_mask[i]};
    end
  end

  // Pick the opened member at the rotation position
  always_comb begin
    prefix   = '0;
    sel_link = '0;
    for (int i = 0; i < MW; i++) begin
      if (emask_q[i] && (prefix == {1'b0, rot})) sel_link = KW'(i);
      prefix = prefix + {{(DW-1){1'b0}}, emask_q[i]};
    end
  end

  // Fragment divisor, rotation step and drop checks
  assign div_sel   = (nb_q == 4'd2) ? 4'd2 : ({1'b0, nb_q[3:1]} + {3'b000, nb_q[0]});
  assign rot_plus  = {1'b0, rot} + 4'd1;
  assign rot_inc   = (rot_plus == nb_q) ? '0 : rot_plus[KW-1:0];
  assign over_mru  = ({4'b0000, len_q} > mru) ||
                     ((mrru != '0) && ({4'b0000, len_q} > mrru));
  assign slot_free = !result_valid || !result_stall;
  assign is_last   = (frag_idx == frag_last_idx);
  assign item_stall = (state != S_IDLE);

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rot           <= '0;
      result_valid  <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (result_valid && !result_stall) result_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            len_q   <= packet_length;
            count_q <= member_count;
            mask_q  <= opened_mask;
            state   <= S_CHECK;
          end
        end

        S_CHECK: begin
          emask_q <= eff_mask;
          nb_q    <= nb_c;
          bundle  <= 1'b0;
          state   <= S_ONE;
          priority if (len_q < mlfs_pkg::MIN_PKT_LEN) begin
            pend_status <= mlfs_pkg::ST_SHORT;
          end else if (len_q >= mlfs_pkg::MAX_FRAME) begin
            pend_status <= mlfs_pkg::ST_OVERSIZE;
          end else if (over_mru) begin
            pend_status <= mlfs_pkg::ST_OVER_MRU;
          end else if (count_q <= 4'd1) begin
            pend_status <= mlfs_pkg::ST_SENT;
          end else if (nb_c == '0) begin
            pend_status <= mlfs_pkg::ST_NO_LINK;
          end else begin
            // advance rotation modulo the opened count
            pend_status      <= mlfs_pkg::ST_SENT;
            bundle           <= 1'b1;
            div_req.start    <= 1'b1;
            div_req.dividend <= {{(LW-DW){1'b0}}, rot_plus};
            div_req.divisor  <= nb_c;
            state            <= S_MOD;
          end
        end

        S_MOD: begin
          if (div_rsp.done) begin
            rot <= div_rsp.remainder[KW-1:0];
            if ((nb_q == 4'd1) || (len_q <= min_frag_len)) begin
              state <= S_ONE;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= len_q;
              div_req.divisor  <= div_sel;
              frag_last_idx    <= 2'(div_sel - 4'd1);
              state            <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            flen     <= div_rsp.quotient;
            off_q    <= '0;
            frag_idx <= '0;
            state    <= S_FRAG;
          end
        end

        S_ONE: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            status       <= pend_status;
            link_index   <= bundle ? sel_link : '0;
            frag_offset  <= '0;
            frag_length  <= (pend_status == mlfs_pkg::ST_SENT) ? len_q : '0;
            mp_header    <= bundle && (nb_q != 4'd1);
            mp_start     <= bundle && (nb_q != 4'd1);
            mp_end       <= bundle && (nb_q != 4'd1);
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end

        S_FRAG: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            status       <= mlfs_pkg::ST_SENT;
            link_index   <= sel_link;
            frag_offset  <= off_q;
            frag_length  <= is_last ? (len_q - off_q) : flen;
            mp_header    <= 1'b1;
            mp_start     <= (frag_idx == 2'd0);
            mp_end       <= is_last;
            last         <= is_last;
            off_q        <= off_q + flen;
            frag_idx     <= frag_idx + 2'd1;
            if (is_last) state <= S_IDLE;
            else         rot   <= rot_inc;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/mlfs_divider.sv
module mlfs_divider (
  input  logic                clk,
  input  logic                rst,
  input  mlfs_pkg::div_req_t  req,
  output mlfs_pkg::div_rsp_t  rsp
);

  localparam int LW = mlfs_pkg::LEN_W;
  localparam int DW = mlfs_pkg::DIV_W;
  localparam int CW = mlfs_pkg::DIV_CNT_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [LW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;

  logic [DW:0]   trial1, trial2, diff1, diff2;
  logic          ge1, ge2;
  logic [DW-1:0] rem1, rem_next;
  logic [LW-1:0] quo1, quo_next;

  // Two restoring steps per cycle
  always_comb begin
    trial1   = {rem, quo[LW-1]};
    diff1    = trial1 - {1'b0, dvs};
    ge1      = trial1 >= {1'b0, dvs};
    rem1     = ge1 ? diff1[DW-1:0] : trial1[DW-1:0];
    quo1     = {quo[LW-2:0], ge1};
    trial2   = {rem1, quo1[LW-1]};
    diff2    = trial2 - {1'b0, dvs};
    ge2      = trial2 >= {1'b0, dvs};
    rem_next = ge2 ? diff2[DW-1:0] : trial2[DW-1:0];
    quo_next = {quo1[LW-2:0], ge2};
  end

  // Load, iterate, flag completion for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= CW'(mlfs_pkg::DIV_STEPS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> design/mlfs_checker.sv
`include "multilink_fragment_scheduler_core_assert.svh"

module mlfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  status,
  input logic [2:0]  link_index,
  input logic [11:0] frag_offset,
  input logic [11:0] frag_length,
  input logic        mp_header,
  input logic        mp_start,
  input logic        mp_end,
  input logic        last
);

  // A dropped packet gives one bare result
  `MLFS_ASSERT_IMPL(a_drop_bare,
    result_valid && (status != 3'(mlfs_pkg::ST_SENT)),
    last && (frag_length == 12'd0) && (link_index == 3'd0) && !mp_header,
    "dropped packet result not bare")

  // A begin fragment starts the packet
  `MLFS_ASSERT_IMPL(a_begin_at_zero,
    result_valid && mp_start,
    (frag_offset == 12'd0) && mp_header,
    "begin fragment off packet start")

  // An end fragment closes the packet
  `MLFS_ASSERT_IMPL(a_end_is_last,
    result_valid && mp_end,
    last && mp_header,
    "end fragment not last")

  // No new packet while one still has fragments to give
  `MLFS_ASSERT_IMPL(a_busy_mid_packet,
    result_valid && !last,
    item_stall,
    "input taken mid packet")

  // A stalled result holds
  `MLFS_ASSERT_NEXT(a_result_hold,
    result_valid && result_stall,
    result_valid && $stable(frag_length) && $stable(link_index) && $stable(frag_offset),
    "stalled result changed")

endmodule

bind multilink_fragment_scheduler_core mlfs_checker u_mlfs_checker (.*);

>>> dv/multilink_fragment_scheduler_core_tb.sv
module multilink_fragment_scheduler_core_tb;

  // One frame leaving the block
  typedef struct packed {
    mlfs_pkg::status_t status;
    logic [2:0]  link_index;
    logic [11:0] frag_offset;
    logic [11:0] frag_length;
    logic        mp_header;
    logic        mp_start;
    logic        mp_end;
    logic        last;
  } frame_t;

  // Directed packet; typed rows carry their status, the rest go through the predictor
  typedef struct {
    logic [11:0] len;
    logic [3:0]  cnt;
    logic [7:0]  mask;
    bit          typed;
    mlfs_pkg::status_t st;
  } probe_t;

  // Register setting and traffic for one random phase
  typedef struct {
    logic [15:0] mru;
    logic [15:0] mrru;
    logic [15:0] min_frag;
    int          items;
    int          mode;
  } phase_t;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [11:0] packet_length = '0;
  logic [3:0]  member_count = '0;
  logic [7:0]  opened_mask = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  status;
  logic [2:0]  link_index;
  logic [11:0] frag_offset;
  logic [11:0] frag_length;
  logic        mp_header;
  logic        mp_start;
  logic        mp_end;
  logic        last;

  // Predictor copy of the registers and of the round-robin position
  logic [15:0] mru_cfg = mlfs_pkg::MRU_RESET;
  logic [15:0] mrru_cfg = mlfs_pkg::MRRU_RESET;
  logic [11:0] min_frag_cfg = mlfs_pkg::MIN_FRAG_RESET;
  int          rotation_pos = 0;

  frame_t      expected_frames [$];
  int          mismatches = 0;
  int          send_idle_pct = 30;
  int          recv_idle_pct = 71;
  int          holds_asked = 0;
  int          send_idle [3] = '{30, 71, 0};
  int          recv_idle [3] = '{71, 30, 0};

  probe_t probes [24] = '{
    '{12'd0,    4'd0,  8'h00, 1'b1, mlfs_pkg::ST_SHORT},
    '{12'd24,   4'd3,  8'hFF, 1'b1, mlfs_pkg::ST_SHORT},
    '{12'd25,   4'd0,  8'h00, 1'b1, mlfs_pkg::ST_SENT},
    '{12'd1500, 4'd1,  8'hFF, 1'b1, mlfs_pkg::ST_SENT},
    '{12'd1501, 4'd0,  8'h00, 1'b1, mlfs_pkg::ST_OVER_MRU},
    '{12'd2047, 4'd2,  8'h03, 1'b1, mlfs_pkg::ST_OVER_MRU},
    '{12'd2048, 4'd0,  8'h00, 1'b1, mlfs_pkg::ST_OVERSIZE},
    '{12'd4095, 4'd15, 8'hFF, 1'b1, mlfs_pkg::ST_OVERSIZE},
    '{12'd100,  4'd2,  8'h00, 1'b1, mlfs_pkg::ST_NO_LINK},
    '{12'd100,  4'd2,  8'hFC, 1'b1, mlfs_pkg::ST_NO_LINK},
    '{12'd100,  4'd8,  8'h00, 1'b1, mlfs_pkg::ST_NO_LINK},
    '{12'd100,  4'd4,  8'h04, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd64,   4'd3,  8'h05, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd65,   4'd2,  8'h03, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd101,  4'd3,  8'h07, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd1000, 4'd4,  8'h0F, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd1499, 4'd5,  8'h1F, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd1500, 4'd8,  8'hFF, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd777,  4'd15, 8'hAA, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd333,  4'd9,  8'h81, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd30,   4'd6,  8'h21, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd1500, 4'd7,  8'h7F, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd26,   4'd8,  8'hFF, 1'b0, mlfs_pkg::ST_SENT},
    '{12'd200,  4'd1,  8'h00, 1'b1, mlfs_pkg::ST_SENT}
  };

  phase_t phases [6] = '{
    '{16'd2047,  16'd0,     16'd64,    40, 0},
    '{16'hFFFF,  16'd1000,  16'd0,     40, 0},
    '{16'd0,     16'hFFFF,  16'hFFFF,  12, 1},
    '{16'd1200,  16'd0,     16'd200,   40, 1},
    '{16'hFFFF,  16'hFFFF,  16'h0FFF,  40, 2},
    '{16'd1500,  16'd0,     16'd16,    40, 2}
  };

  multilink_fragment_scheduler_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .packet_length (packet_length),
    .member_count  (member_count),
    .opened_mask   (opened_mask),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .link_index    (link_index),
    .frag_offset   (frag_offset),
    .frag_length   (frag_length),
    .mp_header     (mp_header),
    .mp_start      (mp_start),
    .mp_end        (mp_end),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the frames a packet causes and queue them; advance the rotation
  task automatic predict_fragments(input logic [11:0] len, input logic [3:0] cnt,
                                   input logic [7:0] mask);
    int     members [8];
    int     nb;
    int     lim;
    int     i;
    int     div;
    int     flen;
    int     last_len;
    int     remain;
    int     k;
    frame_t f;
    nb = 0;
    f = '0;
    f.last = 1'b1;
    if (len < mlfs_pkg::MIN_PKT_LEN) begin
      f.status = mlfs_pkg::ST_SHORT;
      expected_frames.push_back(f);
      return;
    end
    if (len >= mlfs_pkg::MAX_FRAME) begin
      f.status = mlfs_pkg::ST_OVERSIZE;
      expected_frames.push_back(f);
      return;
    end
    if (len > mru_cfg || (mrru_cfg != 0 && len > mrru_cfg)) begin
      f.status = mlfs_pkg::ST_OVER_MRU;
      expected_frames.push_back(f);
      return;
    end
    if (cnt <= 1) begin
      f.frag_length = len;
      expected_frames.push_back(f);
      return;
    end
    // collect opened members in ascending order, ignoring those past the bundle
    lim = (cnt > mlfs_pkg::LINK_LIM) ? mlfs_pkg::LINK_LIM : int'(cnt);
    for (i = 0; i < lim; i++) begin
      if (mask[i]) begin
        members[nb] = i;
        nb++;
      end
    end
    if (nb == 0) begin
      f.status = mlfs_pkg::ST_NO_LINK;
      expected_frames.push_back(f);
      return;
    end
    rotation_pos = (rotation_pos + 1) % nb;
    if (nb == 1) begin
      f.link_index = 3'(members[0]);
      f.frag_length = len;
      expected_frames.push_back(f);
      return;
    end
    f.mp_header = 1'b1;
    f.link_index = 3'(members[rotation_pos]);
    if (len <= min_frag_cfg) begin
      f.frag_length = len;
      f.mp_start = 1'b1;
      f.mp_end = 1'b1;
      expected_frames.push_back(f);
      return;
    end
    // split: two ways for two or three members, else half the members rounded up
    div = (nb == 2) ? 2 : nb / 2 + nb % 2;
    flen = len / div;
    last_len = flen + len % div;
    f.frag_length = 12'(flen);
    f.mp_start = 1'b1;
    f.last = 1'b0;
    expected_frames.push_back(f);
    remain = len - flen;
    k = 1;
    f.mp_start = 1'b0;
    while (remain > last_len && k < 3) begin
      rotation_pos = (rotation_pos + 1) % nb;
      f.link_index = 3'(members[rotation_pos]);
      f.frag_offset = 12'(len - remain);
      expected_frames.push_back(f);
      remain -= flen;
      k++;
    end
    rotation_pos = (rotation_pos + 1) % nb;
    f.link_index = 3'(members[rotation_pos]);
    f.frag_offset = 12'(len - remain);
    f.frag_length = 12'(remain);
    f.mp_end = 1'b1;
    f.last = 1'b1;
    expected_frames.push_back(f);
  endtask

  // Offer one packet after an optional gap and hold it until the transfer
  task automatic offer_packet(input logic [11:0] len, input logic [3:0] cnt,
                              input logic [7:0] mask);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    packet_length <= len;
    member_count <= cnt;
    opened_mask <= mask;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic offer_random_packet();
    logic [11:0] len;
    logic [3:0]  cnt;
    logic [7:0]  mask;
    int          r;
    r = $urandom_range(99);
    if (r < 10) len = 12'($urandom_range(24));
    else if (r < 15) len = 12'($urandom_range(4095, 2048));
    else len = 12'($urandom_range(2047, 25));
    r = $urandom_range(99);
    if (r < 10) cnt = 4'($urandom_range(1));
    else if (r < 85) cnt = 4'($urandom_range(8, 2));
    else cnt = 4'($urandom_range(15, 9));
    r = $urandom_range(99);
    if (r < 8) mask = '0;
    else if (r < 25) mask = 8'(1) << $urandom_range(7);
    else mask = 8'($urandom_range(255, 1));
    offer_packet(len, cnt, mask);
    predict_fragments(len, cnt, mask);
  endtask

  // Drop valid, wait for every expected frame, then let the block settle
  task automatic drain();
    item_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles
  task automatic write_regs(input logic [15:0] mru_v, input logic [15:0] mrru_v,
                            input logic [15:0] min_frag_v);
    cfg_we <= 1'b1;
    cfg_index <= mlfs_pkg::REG_MRU;
    cfg_data <= mru_v;
    @(posedge clk);
    cfg_index <= mlfs_pkg::REG_MRRU;
    cfg_data <= mrru_v;
    @(posedge clk);
    cfg_index <= mlfs_pkg::REG_MIN_FRAG;
    cfg_data <= min_frag_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mru_cfg = mru_v;
    mrru_cfg = mrru_v;
    min_frag_cfg = min_frag_v[11:0];
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receiver: check each transfer, stall at random, serve long hold-offs on request
  always @(posedge clk) begin : receiver
    static int hold_left = 0;
    static int holds_done = 0;
    frame_t    exp_f;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_frames.size() == 0) begin
          $error("result with no packet outstanding: status %0d link %0d", status,
                 link_index);
          mismatches++;
        end else begin
          exp_f = expected_frames.pop_front();
          compare_field("status", exp_f.status, status);
          compare_field("link_index", exp_f.link_index, link_index);
          compare_field("frag_offset", exp_f.frag_offset, frag_offset);
          compare_field("frag_length", exp_f.frag_length, frag_length);
          compare_field("mp_header", exp_f.mp_header, mp_header);
          compare_field("mp_start", exp_f.mp_start, mp_start);
          compare_field("mp_end", exp_f.mp_end, mp_end);
          compare_field("last", exp_f.last, last);
        end
      end
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : sequencer
    int     n;
    int     p;
    frame_t f;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed packets with the reset register values
    for (n = 0; n < 24; n++) begin
      offer_packet(probes[n].len, probes[n].cnt, probes[n].mask);
      if (probes[n].typed) begin
        f = '0;
        f.status = probes[n].st;
        f.frag_length = (probes[n].st == mlfs_pkg::ST_SENT) ? probes[n].len : '0;
        f.last = 1'b1;
        expected_frames.push_back(f);
      end else begin
        predict_fragments(probes[n].len, probes[n].cnt, probes[n].mask);
      end
    end

    // random phases, each under its own register setting
    for (p = 0; p < 6; p++) begin
      drain();
      write_regs(phases[p].mru, phases[p].mrru, phases[p].min_frag);
      send_idle_pct = send_idle[phases[p].mode];
      recv_idle_pct <= recv_idle[phases[p].mode];
      if (p == 1) holds_asked <= holds_asked + 1;
      for (n = 0; n < phases[p].items; n++) offer_random_packet();
    end

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/mlfs_pkg.sv
design/mlfs_divider.sv
design/multilink_fragment_scheduler_core.sv
design/mlfs_checker.sv
dv/multilink_fragment_scheduler_core_tb.sv
